>>> rtl/segment_window_missing_tracker_assert.svh
// assertion macros for the segment window missing tracker
`ifndef SEGMENT_WINDOW_MISSING_TRACKER_ASSERT_SVH
`define SEGMENT_WINDOW_MISSING_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define SWMT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWMT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SWMT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWMT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> rtl/swmt_pkg.sv
// shared types and constants for the segment window missing tracker
package swmt_pkg;

	localparam int WINDOW_BITS_DEF = 64;
	localparam int SEGMENT_BYTES   = 16;
	localparam int PAGE_BYTES      = 1024;
	localparam int SEG_SHIFT       = $clog2(SEGMENT_BYTES);
	localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);

	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 21;
	localparam int LEN_W     = 8;
	localparam int CMD_W     = 3;
	localparam int STATUS_W  = 3;
	localparam int ELEN_W    = 5;
	localparam int SEG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	localparam logic [LEN_W-1:0]  LEN_ALIGN_MASK = 8'h03;
	localparam logic [ELEN_W-1:0] ENTRY_LEN      = ELEN_W'(SEGMENT_BYTES);

	localparam logic [CFG_IDX_W-1:0] CFG_BANK_ADDR  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BYTES = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_START  = 3'd0,
		CMD_DATA   = 3'd1,
		CMD_WDONE  = 3'd2,
		CMD_HAS    = 3'd3,
		CMD_OLDEST = 3'd4,
		CMD_END    = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_BAD_STATE = 3'd1,
		STS_BAD_ADDR  = 3'd2,
		STS_BAD_LEN   = 3'd3,
		STS_BUSY      = 3'd4,
		STS_ABORT     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		WOP_HOLD       = 3'd0,
		WOP_CLEAR      = 3'd1,
		WOP_FILL       = 3'd2,
		WOP_SHIFT      = 3'd3,
		WOP_SHIFT_LAST = 3'd4,
		WOP_CLR_BIT    = 3'd5
	} wop_t;

	typedef struct packed {
		logic rd_bit;
		logic msb;
		logic any;
	} win_stat_t;

endpackage

>>> rtl/segment_window_missing_tracker.sv
// top level of the segment window missing tracker
//
// requests: start is sampled with command, address and length; a request is
// taken at a clock edge where start is high and busy is low.
// results: done is high for exactly one cycle with status, found,
// result_addr and entry_length; the receiver cannot stall, so a result is
// never held back and busy drops on the same edge that raises done.
// config: cfg_we writes cfg_wdata into register cfg_index (0 bank_addr,
// 1 size_bytes) at the clock edge; write only while busy is low.
// sequence after the accepting edge:
//   start, write done, end, unused codes: finish in the prep state
//   data, has-entry query: prep, then decide; a data item that advances the window
//   by n < WINDOW_BITS segments then slides n times, one window shift per cycle
//   oldest-missing query: prep, decide, then k scan steps (1..WINDOW_BITS),
//   one window bit compared per cycle
// a new request may be presented in the cycle that done is high.
// reset clears the transfer state, the window and both config registers at
// once; there is no clearing pass.
module segment_window_missing_tracker #(
	parameter int WINDOW_BITS = swmt_pkg::WINDOW_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [swmt_pkg::CMD_W-1:0]       command,
	input  logic [swmt_pkg::ADDR_W-1:0]      address,
	input  logic [swmt_pkg::LEN_W-1:0]       length,
	output logic                             done,
	output logic [swmt_pkg::STATUS_W-1:0]    status,
	output logic                             found,
	output logic [swmt_pkg::ADDR_W-1:0]      result_addr,
	output logic [swmt_pkg::ELEN_W-1:0]      entry_length,
	input  logic                             cfg_we,
	input  logic [swmt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swmt_pkg::CFG_W-1:0]       cfg_wdata
);
	import swmt_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_BITS);

	logic [ADDR_W-1:0] bank_addr_q;
	logic [SIZE_W-1:0] size_bytes_q;
	wop_t              win_op;
	logic [IDX_W-1:0]  win_idx;
	win_stat_t         win_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_addr_q  <= '0;
			size_bytes_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
			CFG_BANK_ADDR: begin
				bank_addr_q <= cfg_wdata[ADDR_W-1:0];
			end
			CFG_SIZE_BYTES: begin
				size_bytes_q <= cfg_wdata[SIZE_W-1:0];
			end
			default: begin
				bank_addr_q <= bank_addr_q;
			end
			endcase
		end
	end

	swmt_window #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (win_op),
		.idx    (win_idx),
		.stat   (win_stat)
	);

	swmt_ctrl #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.address      (address),
		.length       (length),
		.bank_addr    (bank_addr_q),
		.size_bytes   (size_bytes_q),
		.win_op       (win_op),
		.win_idx      (win_idx),
		.win_stat     (win_stat),
		.done         (done),
		.status       (status),
		.found        (found),
		.result_addr  (result_addr),
		.entry_length (entry_length)
	);

endmodule

>>> rtl/swmt_window.sv
// missing-mark window register with its one-bit shift unit
module swmt_window #(
	parameter int WINDOW_BITS = swmt_pkg::WINDOW_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swmt_pkg::wop_t                 op,
	input  logic [$clog2(WINDOW_BITS)-1:0] idx,
	output swmt_pkg::win_stat_t            stat
);
	import swmt_pkg::*;

	logic [WINDOW_BITS-1:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else begin
			case (op)
			WOP_CLEAR: begin
				win_q <= '0;
			end
			WOP_FILL: begin
				win_q <= {{(WINDOW_BITS-1){1'b1}}, 1'b0};
			end
			WOP_SHIFT: begin
				win_q <= {win_q[WINDOW_BITS-2:0], 1'b1};
			end
			WOP_SHIFT_LAST: begin
				win_q <= {win_q[WINDOW_BITS-2:0], 1'b0};
			end
			WOP_CLR_BIT: begin
				win_q[idx] <= 1'b0;
			end
			default: begin
				win_q <= win_q;
			end
			endcase
		end
	end

	always_comb begin
		stat.rd_bit = win_q[idx];
		stat.msb    = win_q[WINDOW_BITS-1];
		stat.any    = |win_q;
	end

endmodule

>>> rtl/swmt_ctrl.sv
// request sequencer, transfer state and result register
`include "segment_window_missing_tracker_assert.svh"

module swmt_ctrl #(
	parameter int WINDOW_BITS = swmt_pkg::WINDOW_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [swmt_pkg::CMD_W-1:0]     command,
	input  logic [swmt_pkg::ADDR_W-1:0]    address,
	input  logic [swmt_pkg::LEN_W-1:0]     length,
	input  logic [swmt_pkg::ADDR_W-1:0]    bank_addr,
	input  logic [swmt_pkg::SIZE_W-1:0]    size_bytes,
	output swmt_pkg::wop_t                 win_op,
	output logic [$clog2(WINDOW_BITS)-1:0] win_idx,
	input  swmt_pkg::win_stat_t            win_stat,
	output logic                           done,
	output logic [swmt_pkg::STATUS_W-1:0]  status,
	output logic                           found,
	output logic [swmt_pkg::ADDR_W-1:0]    result_addr,
	output logic [swmt_pkg::ELEN_W-1:0]    entry_length
);
	import swmt_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_BITS);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PREP   = 5'b00010,
		S_DECIDE = 5'b00100,
		S_SLIDE  = 5'b01000,
		S_SCAN   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;

	logic              active_q;
	logic [ADDR_W-1:0] start_base_q;
	logic [SEG_W-1:0]  max_seg_q;
	logic              pend_q;
	logic [SEG_W-1:0]  pend_seg_q;

	logic [ADDR_W:0]   diff_q;
	logic [ADDR_W:0]   lim_q;
	logic [SEG_W-1:0]  seg_q;
	logic [ADDR_W-1:0] raddr_q;
	logic              lost_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [SEG_W-1:0]  scan_seg_q;
	logic [ADDR_W-1:0] scan_addr_q;

	logic              done_q;
	status_t           status_q;
	logic              found_q;
	logic [ADDR_W-1:0] result_addr_q;
	logic [ELEN_W-1:0] entry_length_q;

	logic [SEG_W-1:0]  seg;
	logic              seg_gt;
	logic [SEG_W-1:0]  seg_dist;
	logic              in_win;
	logic [SEG_W-1:0]  off;
	logic              off_big;
	logic              missing;
	logic [SEG_W-1:0]  wd_dist;
	logic [ADDR_W-1:0] bank_sel;
	logic [ADDR_W-1:0] add_b;
	logic [ADDR_W-1:0] sum;
	logic [ADDR_W:0]   end_sum;
	logic              addr_bad;
	logic              len_bad;
	logic [SEG_W-1:0]  s0;
	logic [ADDR_W-1:0] a0;
	logic              hit;
	logic [ADDR_W-1:0] scan_addr_nx;
	logic              lost_now;
	logic [SEG_W-1:0]  seg_sel;

	logic              fin;
	status_t           fin_status;
	logic              fin_found;
	logic [ADDR_W-1:0] fin_raddr;
	logic [ELEN_W-1:0] fin_elen;
	logic              do_clear;
	logic              set_active;
	logic              deact;
	logic              set_max;
	logic              set_pend;
	logic              clr_pend;
	logic              go_slide;
	logic              go_scan;

	assign seg      = diff_q[SEG_SHIFT +: SEG_W];
	assign seg_gt   = seg > max_seg_q;
	assign seg_dist = max_seg_q - seg;
	assign in_win   = seg_dist < SEG_W'(WINDOW_BITS);
	assign off      = seg - max_seg_q;
	assign off_big  = off >= SEG_W'(WINDOW_BITS);
	assign missing  = seg_gt || (in_win && win_stat.rd_bit);
	assign wd_dist  = max_seg_q - pend_seg_q;
	assign bank_sel = (bank_addr != '0) ? bank_addr : start_base_q;
	assign add_b    = (cmd_q == CMD_DATA) ? diff_q[ADDR_W-1:0]
		: (ADDR_W'(seg) << SEG_SHIFT);
	assign sum      = bank_sel + add_b;
	assign end_sum  = {1'b0, addr_q} + (ADDR_W+1)'(len_q);
	assign addr_bad = (addr_q[SEG_SHIFT-1:0] != '0) || diff_q[ADDR_W] || (end_sum > lim_q);
	assign len_bad  = (len_q > LEN_W'(SEGMENT_BYTES)) || ((len_q & LEN_ALIGN_MASK) != '0);
	assign s0       = max_seg_q - SEG_W'(WINDOW_BITS - 1);
	assign a0       = start_base_q + (ADDR_W'(s0) << SEG_SHIFT);
	assign hit      = win_stat.rd_bit && (scan_addr_q >= addr_q);
	assign scan_addr_nx = (scan_seg_q == '1) ? start_base_q
		: scan_addr_q + ADDR_W'(SEGMENT_BYTES);
	assign lost_now = lost_q || win_stat.msb;
	assign seg_sel  = (state_q == S_SLIDE) ? seg_q : seg;

	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		fin_status = STS_OK;
		fin_found  = 1'b0;
		fin_raddr  = '0;
		fin_elen   = '0;
		win_op     = WOP_HOLD;
		win_idx    = seg_dist[IDX_W-1:0];
		do_clear   = 1'b0;
		set_active = 1'b0;
		deact      = 1'b0;
		set_max    = 1'b0;
		set_pend   = 1'b0;
		clr_pend   = 1'b0;
		go_slide   = 1'b0;
		go_scan    = 1'b0;
		case (state_q)
		S_IDLE: begin
			if (start) begin
				state_d = S_PREP;
			end
		end
		S_PREP: begin
			case (cmd_q)
			CMD_START: begin
				do_clear = 1'b1;
				win_op   = WOP_CLEAR;
				if (addr_q[PAGE_SHIFT-1:0] != '0 || bank_addr[PAGE_SHIFT-1:0] != '0) begin
					fin_status = STS_BAD_ADDR;
				end else begin
					set_active = 1'b1;
				end
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			CMD_WDONE: begin
				win_idx = wd_dist[IDX_W-1:0];
				if (pend_q) begin
					clr_pend = 1'b1;
					if (wd_dist < SEG_W'(WINDOW_BITS)) begin
						win_op = WOP_CLR_BIT;
					end
				end
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			CMD_END: begin
				do_clear = 1'b1;
				win_op   = WOP_CLEAR;
				fin      = 1'b1;
				state_d  = S_IDLE;
			end
			CMD_DATA, CMD_HAS, CMD_OLDEST: begin
				state_d = S_DECIDE;
			end
			default: begin
				fin_status = STS_BAD_STATE;
				fin        = 1'b1;
				state_d    = S_IDLE;
			end
			endcase
		end
		S_DECIDE: begin
			state_d = S_IDLE;
			case (cmd_q)
			CMD_DATA: begin
				fin = 1'b1;
				if (!active_q) begin
					fin_status = STS_BAD_STATE;
				end else if (addr_bad) begin
					fin_status = STS_BAD_ADDR;
				end else if (len_bad) begin
					fin_status = STS_BAD_LEN;
				end else if (pend_q) begin
					fin_status = STS_BUSY;
				end else if (!missing) begin
					fin_status = STS_BAD_STATE;
				end else if (seg_gt && off_big && win_stat.any) begin
					fin_status = STS_ABORT;
					deact      = 1'b1;
				end else if (seg_gt && off_big) begin
					win_op    = WOP_FILL;
					set_max   = 1'b1;
					set_pend  = 1'b1;
					fin_raddr = sum;
				end else if (seg_gt) begin
					fin      = 1'b0;
					go_slide = 1'b1;
					state_d  = S_SLIDE;
				end else begin
					set_pend  = 1'b1;
					fin_raddr = sum;
				end
			end
			CMD_HAS: begin
				fin = 1'b1;
				if (active_q && !missing) begin
					fin_found = 1'b1;
					fin_raddr = sum;
				end
			end
			CMD_OLDEST: begin
				if (active_q) begin
					go_scan = 1'b1;
					state_d = S_SCAN;
				end else begin
					fin = 1'b1;
				end
			end
			default: begin
				fin = 1'b1;
			end
			endcase
		end
		S_SLIDE: begin
			if (cnt_q == IDX_W'(1)) begin
				fin     = 1'b1;
				state_d = S_IDLE;
				if (lost_now) begin
					fin_status = STS_ABORT;
					deact      = 1'b1;
				end else begin
					win_op    = WOP_SHIFT_LAST;
					set_max   = 1'b1;
					set_pend  = 1'b1;
					fin_raddr = raddr_q;
				end
			end else begin
				win_op = WOP_SHIFT;
			end
		end
		S_SCAN: begin
			win_idx = scan_idx_q;
			if (hit) begin
				fin       = 1'b1;
				fin_found = 1'b1;
				fin_raddr = scan_addr_q;
				fin_elen  = ENTRY_LEN;
				state_d   = S_IDLE;
			end else if (scan_idx_q == '0) begin
				fin     = 1'b1;
				state_d = S_IDLE;
			end
		end
		default: begin
			state_d = S_IDLE;
		end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			active_q     <= 1'b0;
			start_base_q <= '0;
			max_seg_q    <= '0;
			pend_q       <= 1'b0;
			pend_seg_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (do_clear) begin
				active_q     <= 1'b0;
				start_base_q <= '0;
				max_seg_q    <= '0;
				pend_q       <= 1'b0;
				pend_seg_q   <= '0;
			end
			if (set_active) begin
				active_q     <= 1'b1;
				start_base_q <= addr_q;
			end
			if (deact) begin
				active_q <= 1'b0;
			end
			if (set_max) begin
				max_seg_q <= seg_sel;
			end
			if (set_pend) begin
				pend_q     <= 1'b1;
				pend_seg_q <= seg_sel;
			end
			if (clr_pend) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q  <= cmd_t'(command);
			addr_q <= address;
			len_q  <= length;
		end
		if (state_q == S_PREP) begin
			diff_q <= {1'b0, addr_q} - {1'b0, start_base_q};
			lim_q  <= {1'b0, start_base_q} + (ADDR_W+1)'(size_bytes);
		end
		if (go_slide) begin
			cnt_q   <= off[IDX_W-1:0];
			lost_q  <= 1'b0;
			seg_q   <= seg;
			raddr_q <= sum;
		end else if (state_q == S_SLIDE) begin
			cnt_q  <= cnt_q - IDX_W'(1);
			lost_q <= lost_now;
		end
		if (go_scan) begin
			scan_idx_q  <= IDX_W'(WINDOW_BITS - 1);
			scan_seg_q  <= s0;
			scan_addr_q <= a0;
		end else if (state_q == S_SCAN) begin
			scan_idx_q  <= scan_idx_q - IDX_W'(1);
			scan_seg_q  <= scan_seg_q + SEG_W'(1);
			scan_addr_q <= scan_addr_nx;
		end
		if (fin) begin
			status_q       <= fin_status;
			found_q        <= fin_found;
			result_addr_q  <= fin_raddr;
			entry_length_q <= fin_elen;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign found        = found_q;
	assign result_addr  = result_addr_q;
	assign entry_length = entry_length_q;

	`SWMT_ASSERT(a_accept_busy, clk, arst_n, (start && !busy) |=> busy, "request not taken")
	`SWMT_ASSERT(a_done_single, clk, arst_n, done |=> !done, "result strobe held two cycles")
	`SWMT_ASSERT(a_pend_active, clk, arst_n, pend_q |-> active_q, "pending write while inactive")
	`SWMT_ASSERT(a_pend_order, clk, arst_n, pend_q |-> (pend_seg_q <= max_seg_q), "pending seg past max")
	`SWMT_ASSERT_NEVER(a_slide_cnt, clk, arst_n, (state_q == S_SLIDE) && (cnt_q == '0), "slide count empty")

endmodule

>>> bench/segment_tracker_checker.sv
// segment window tracker checker: predicts each result and compares it with the block's output
`timescale 1ns / 1ps

module segment_tracker_checker
	import swmt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [ADDR_W-1:0]    address,
	input  logic [LEN_W-1:0]     length,
	input  logic                 done,
	input  logic [STATUS_W-1:0]  status,
	input  logic                 found,
	input  logic [ADDR_W-1:0]    result_addr,
	input  logic [ELEN_W-1:0]    entry_length,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   err_count,
	output int                   pending_results,
	output int                   results_seen,
	output int                   abort_count,
	output int                   hit_count
);

	localparam int WIN = WINDOW_BITS_DEF;
	localparam logic [WIN-1:0] WIN_ONE = 1;

	typedef struct packed {
		status_t             status;
		logic                found;
		logic [ADDR_W-1:0]   raddr;
		logic [ELEN_W-1:0]   elen;
	} tracker_reply_t;

	tracker_reply_t reply_q[$];
	tracker_reply_t want;

	logic [ADDR_W-1:0] bank_reg;
	logic [SIZE_W-1:0] size_reg;
	logic              run_active;
	logic [ADDR_W-1:0] img_base;
	logic [SEG_W-1:0]  top_seg;
	logic [WIN-1:0]    miss_win;
	logic              wr_pending;
	logic [SEG_W-1:0]  pend_seg;

	function automatic void clear_run();
		run_active = 1'b0;
		img_base   = '0;
		top_seg    = '0;
		miss_win   = '0;
		wr_pending = 1'b0;
		pend_seg   = '0;
	endfunction

	function automatic logic [ADDR_W-1:0] write_bank();
		return (bank_reg != '0) ? bank_reg : img_base;
	endfunction

	function automatic logic seg_is_missing(input logic [SEG_W-1:0] seg);
		logic [SEG_W-1:0] span;
		if (seg > top_seg)
			return 1'b1;
		span = top_seg - seg;
		if (span >= WIN)
			return 1'b0;
		return miss_win[span];
	endfunction

	function automatic tracker_reply_t predict_reply(input logic [CMD_W-1:0] cmd,
		input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
		tracker_reply_t r;
		logic [SEG_W-1:0] seg, off, span, s;
		logic [ADDR_W-1:0] rel, a;
		logic [WIN-1:0] w;
		logic lost;
		r = '0;
		r.status = STS_OK;
		case (cmd)
			CMD_START: begin
				clear_run();
				if ((addr % PAGE_BYTES) != 0 || (bank_reg % PAGE_BYTES) != 0) begin
					r.status = STS_BAD_ADDR;
				end else begin
					run_active = 1'b1;
					img_base = addr;
				end
			end
			CMD_DATA: begin
				if (!run_active) begin
					r.status = STS_BAD_STATE;
				end else if ((addr % SEGMENT_BYTES) != 0 || addr < img_base ||
						({1'b0, addr} + 33'(len) > {1'b0, img_base} + 33'(size_reg))) begin
					r.status = STS_BAD_ADDR;
				end else if (len > SEGMENT_BYTES || (len & LEN_ALIGN_MASK) != '0) begin
					r.status = STS_BAD_LEN;
				end else if (wr_pending) begin
					r.status = STS_BUSY;
				end else begin
					rel = addr - img_base;
					seg = SEG_W'(rel / SEGMENT_BYTES);
					if (!seg_is_missing(seg)) begin
						r.status = STS_BAD_STATE;
					end else begin
						if (seg > top_seg) begin
							off = seg - top_seg;
							w = miss_win;
							if (off >= WIN)
								lost = (w != '0);
							else
								lost = ((w >> (WIN - off)) != '0);
							if (lost) begin
								run_active = 1'b0;
								r.status = STS_ABORT;
							end else begin
								if (off >= WIN)
									w = '1;
								else
									w = (w << off) | ((WIN_ONE << off) - WIN_ONE);
								miss_win = w & ~WIN_ONE;
								top_seg = seg;
							end
						end
						if (r.status == STS_OK) begin
							pend_seg = seg;
							wr_pending = 1'b1;
							r.raddr = write_bank() + rel;
						end
					end
				end
			end
			CMD_WDONE: begin
				if (wr_pending) begin
					span = top_seg - pend_seg;
					if (span < WIN)
						miss_win[span] = 1'b0;
					wr_pending = 1'b0;
				end
			end
			CMD_HAS: begin
				if (run_active) begin
					seg = SEG_W'((addr - img_base) / SEGMENT_BYTES);
					if (seg <= top_seg && !seg_is_missing(seg)) begin
						r.found = 1'b1;
						r.raddr = write_bank() + (ADDR_W'(seg) << SEG_SHIFT);
					end
				end
			end
			CMD_OLDEST: begin
				if (run_active) begin
					for (int i = WIN - 1; i >= 0; i--) begin
						if (!r.found && miss_win[i]) begin
							s = top_seg - SEG_W'(i);
							a = img_base + (ADDR_W'(s) << SEG_SHIFT);
							if (a >= addr) begin
								r.found = 1'b1;
								r.raddr = a;
								r.elen = ENTRY_LEN;
							end
						end
					end
				end
			end
			CMD_END: begin
				clear_run();
			end
			default: begin
				r.status = STS_BAD_STATE;
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			reply_q.delete();
			bank_reg = '0;
			size_reg = '0;
			clear_run();
			err_count = 0;
			results_seen = 0;
			abort_count = 0;
			hit_count = 0;
		end else begin
			if (done) begin
				results_seen++;
				if (reply_q.size() == 0) begin
					if (err_count < 10)
						$display("unexpected result: status %0d found %0b addr %h len %0d",
							status, found, result_addr, entry_length);
					err_count++;
				end else begin
					want = reply_q.pop_front();
					if (status !== want.status || found !== want.found ||
							result_addr !== want.raddr || entry_length !== want.elen) begin
						if (err_count < 10)
							$display("result mismatch: expected %0d %0b %h %0d, got %0d %0b %h %0d",
								want.status, want.found, want.raddr, want.elen,
								status, found, result_addr, entry_length);
						err_count++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_BANK_ADDR)
					bank_reg = cfg_wdata[ADDR_W-1:0];
				else if (cfg_index == CFG_SIZE_BYTES)
					size_reg = cfg_wdata[SIZE_W-1:0];
			end
			if (start && !busy) begin
				want = predict_reply(command, address, length);
				if (want.status == STS_ABORT)
					abort_count++;
				if (want.found)
					hit_count++;
				reply_q.push_back(want);
			end
		end
		pending_results <= reply_q.size();
	end

endmodule

>>> bench/tb.sv
// testbench top for the segment window missing tracker: stimulus, config phases and verdict
`timescale 1ns / 1ps

module tb;
	import swmt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam int NUM_PHASES = 6;
	localparam int SIZE_MAX = 1048576;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [CMD_W-1:0]     command;
	logic [ADDR_W-1:0]    address;
	logic [LEN_W-1:0]     length;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic                 found;
	logic [ADDR_W-1:0]    result_addr;
	logic [ELEN_W-1:0]    entry_length;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	int err_count, pending_results, results_seen, abort_count, hit_count;
	int sent;
	int idle_pct;

	logic [ADDR_W-1:0] phase_bank [NUM_PHASES] = '{32'h0000_0000, 32'hFFFF_FC00,
		32'h0004_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};
	int phase_size [NUM_PHASES] = '{SIZE_MAX, SIZE_MAX, 0, 4096, 2048, 65536};
	int phase_items [NUM_PHASES] = '{200, 200, 60, 60, 220, 220};
	int phase_idle [NUM_PHASES] = '{0, 76, 0, 27, 27, 76};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_window_missing_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .address(address), .length(length),
		.done(done), .status(status), .found(found),
		.result_addr(result_addr), .entry_length(entry_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	segment_tracker_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .address(address), .length(length),
		.done(done), .status(status), .found(found),
		.result_addr(result_addr), .entry_length(entry_length),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.err_count(err_count), .pending_results(pending_results),
		.results_seen(results_seen), .abort_count(abort_count), .hit_count(hit_count)
	);

	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0] len);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		command <= cmd;
		address <= addr;
		length  <= len;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain_requests();
		start <= 1'b0;
		@(negedge clk);
		while (pending_results != 0 || busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic load_config(input logic [ADDR_W-1:0] bank, input int size);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BANK_ADDR;
		cfg_wdata <= bank;
		@(posedge clk);
		cfg_index <= CFG_SIZE_BYTES;
		cfg_wdata <= CFG_W'(size);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ADDR_W-1:0] seg_addr(input logic [ADDR_W-1:0] base, input int seg);
		return base + (ADDR_W'(seg) << SEG_SHIFT);
	endfunction

	// one transfer: start, then mostly in-order writes with write done, plus queries and noise
	task automatic run_transfer(input int target);
		int n_ops, hi, seg, r, q, k;
		logic [ADDR_W-1:0] base, bound;
		r = $urandom_range(9);
		if (r == 0)
			base = '0;
		else if (r == 1)
			base = 32'hFFFF_FC00;
		else
			base = $urandom & 32'hFFFF_FC00;
		if ($urandom_range(19) == 0)
			base = base | (ADDR_W'($urandom_range(1, 63)) << SEG_SHIFT);
		issue(CMD_START, base, LEN_W'($urandom));
		hi = 0;
		n_ops = $urandom_range(20, 90);
		for (k = 0; k < n_ops && sent < target; k++) begin
			r = $urandom_range(99);
			if (r < 50) begin
				q = $urandom_range(9);
				if (q < 6)
					seg = hi + int'($urandom_range(1, 3));
				else if (q < 9)
					seg = hi - int'($urandom_range(0, 70));
				else
					seg = hi + int'($urandom_range(4, 63));
				if (seg < 0)
					seg = 0;
				issue(CMD_DATA, seg_addr(base, seg), LEN_W'(4 * $urandom_range(0, 4)));
				if (seg > hi)
					hi = seg;
				if ($urandom_range(99) < 85)
					issue(CMD_WDONE, $urandom, LEN_W'($urandom));
			end else if (r < 60) begin
				seg = hi - int'($urandom_range(0, 80));
				if (seg < 0)
					seg = 0;
				issue(CMD_HAS, seg_addr(base, seg), LEN_W'($urandom));
			end else if (r < 70) begin
				q = $urandom_range(9);
				seg = hi - int'($urandom_range(0, 70));
				if (seg < 0)
					seg = 0;
				if (q < 4)
					bound = base;
				else if (q < 8)
					bound = seg_addr(base, seg);
				else
					bound = $urandom;
				issue(CMD_OLDEST, bound, LEN_W'($urandom));
			end else if (r < 78) begin
				if ($urandom_range(2) == 0)
					bound = $urandom;
				else
					bound = seg_addr(base, $urandom_range(0, hi + 8)) +
						ADDR_W'($urandom_range(0, 15));
				issue(CMD_DATA, bound, LEN_W'($urandom_range(0, 255)));
			end else if (r < 81) begin
				seg = hi + int'($urandom_range(64, 400));
				issue(CMD_DATA, seg_addr(base, seg), LEN_W'(SEGMENT_BYTES));
				hi = seg;
				issue(CMD_WDONE, $urandom, LEN_W'($urandom));
			end else if (r < 86) begin
				issue(CMD_WDONE, $urandom, LEN_W'($urandom));
			end else if (r < 90) begin
				issue(($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI,
					$urandom, LEN_W'($urandom));
			end else if (r < 92) begin
				issue(CMD_END, $urandom, LEN_W'($urandom));
				k = n_ops;
			end else if (r < 94) begin
				issue(CMD_START, base, LEN_W'($urandom));
				hi = 0;
			end else begin
				seg = hi + 1;
				issue(CMD_DATA, seg_addr(base, seg), LEN_W'(SEGMENT_BYTES));
				hi = seg;
				issue(CMD_WDONE, $urandom, LEN_W'($urandom));
			end
		end
	endtask

	initial begin
		logic [ADDR_W-1:0] b;
		int p, target;
		arst_n    = 1'b0;
		start     = 1'b0;
		command   = '0;
		address   = '0;
		length    = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sent      = 0;
		idle_pct  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_config('0, SIZE_MAX);
		b = 32'h0001_0000;
		issue(CMD_DATA, b, 8'd16);
		issue(CMD_HAS, b, 8'd0);
		issue(CMD_OLDEST, '0, 8'd0);
		issue(CMD_START, b | 32'h0000_0200, 8'd0);
		issue(CMD_START, b, 8'd0);
		issue(CMD_DATA, b, 8'd16);
		issue(CMD_DATA, seg_addr(b, 1), 8'd16);
		issue(CMD_DATA, seg_addr(b, 2), 8'd16);
		issue(CMD_WDONE, '0, 8'd0);
		issue(CMD_WDONE, '0, 8'd0);
		issue(CMD_DATA, b + 32'h18, 8'd8);
		issue(CMD_DATA, b - 32'd16, 8'd16);
		issue(CMD_DATA, seg_addr(b, 3), 8'd3);
		issue(CMD_DATA, seg_addr(b, 3), 8'd20);
		issue(CMD_DATA, seg_addr(b, 3), 8'hFF);
		issue(CMD_DATA, seg_addr(b, 5), 8'd0);
		issue(CMD_WDONE, '0, 8'd0);
		issue(CMD_HAS, seg_addr(b, 3), 8'd0);
		issue(CMD_HAS, seg_addr(b, 1), 8'd0);
		issue(CMD_OLDEST, b, 8'd0);
		issue(CMD_OLDEST, '1, 8'd0);
		issue(CMD_DATA, seg_addr(b, 200), 8'd16);
		issue(CMD_SPARE_LO, '1, '1);
		issue(CMD_SPARE_HI, '0, '0);
		issue(CMD_START, 32'hFFFF_FC00, 8'd0);
		issue(CMD_DATA, 32'hFFFF_FFF0, 8'd16);
		issue(CMD_WDONE, '0, 8'd0);
		issue(CMD_OLDEST, '0, 8'd0);
		issue(CMD_START, '0, 8'd0);
		issue(CMD_DATA, 32'h000F_FFF0, 8'd16);
		issue(CMD_WDONE, '0, 8'd0);
		issue(CMD_OLDEST, '0, 8'd0);
		issue(CMD_DATA, 32'h0010_0000, 8'd4);
		issue(CMD_END, '0, 8'd0);

		for (p = 0; p < NUM_PHASES; p++) begin
			drain_requests();
			repeat (4) @(posedge clk);
			if (p == 4)
				phase_bank[p] = $urandom & 32'hFFFF_FC00;
			load_config(phase_bank[p], phase_size[p]);
			idle_pct = phase_idle[p];
			target = sent + phase_items[p];
			while (sent < target)
				run_transfer(target);
		end

		drain_requests();
		repeat (70) @(posedge clk);
		@(negedge clk);
		$display("%0d requests over %0d config settings, %0d results compared",
			sent, NUM_PHASES, results_seen);
		$display("%0d transfers aborted on a lost segment, %0d queries with a hit",
			abort_count, hit_count);
		if (err_count == 0 && pending_results == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
